// ===== src/prrs_pkg.sv =====
package prrs_pkg;

  localparam int MaxTasks = 16;
  localparam int IdxW = $clog2(MaxTasks);
  localparam int CntW = $clog2(MaxTasks + 1);

  localparam logic [1:0] StReady = 2'd0;
  localparam logic [1:0] StRun   = 2'd1;
  localparam logic [1:0] StSleep = 2'd2;
  localparam logic [1:0] StDead  = 2'd3;

  localparam logic [2:0] OpTick   = 3'd0;
  localparam logic [2:0] OpCreate = 3'd1;
  localparam logic [2:0] OpYield  = 3'd2;
  localparam logic [2:0] OpSleep  = 3'd3;
  localparam logic [2:0] OpWake   = 3'd4;
  localparam logic [2:0] OpExit   = 3'd5;
  localparam logic [2:0] OpSetPri = 3'd6;
  localparam logic [2:0] OpStart  = 3'd7;

  localparam logic [1:0] StsOk      = 2'd0;
  localparam logic [1:0] StsFull    = 2'd1;
  localparam logic [1:0] StsBadIdx  = 2'd2;
  localparam logic [1:0] StsNoCur   = 2'd3;

  localparam logic [1:0] RegQuantum = 2'd0;
  localparam logic [1:0] RegFloor   = 2'd1;
  localparam logic [1:0] RegCeiling = 2'd2;

  // scan kinds: wake sweep, best-in-rotation, strictly-higher
  typedef enum logic [1:0] {
    ScanWake = 2'd0,
    ScanNext = 2'd1,
    ScanHigh = 2'd2
  } scan_e;

  // controller -> datapath
  typedef struct packed {
    logic  load;      // latch input item, do immediate work
    logic  scan_init; // start a scan
    scan_e scan_kind;
    logic  scan_step; // process one entry
    logic  tick_post; // quantum handling after wake sweep
    logic  resched;   // finish reschedule after next scan
    logic  start_fin; // finish start after next scan
    logic  tick_fin;  // finish tick after its pick scan
    logic  emit;      // present result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic       scan_last;
    logic [2:0] next_act; // what follows load or tick_post
  } sts_t;

  localparam logic [2:0] ActDone  = 3'd0;
  localparam logic [2:0] ActWake  = 3'd1;
  localparam logic [2:0] ActNext  = 3'd2; // reschedule pick
  localparam logic [2:0] ActStart = 3'd3;
  localparam logic [2:0] ActHigh  = 3'd4;
  localparam logic [2:0] ActQEnd  = 3'd5; // quantum expired pick

  function automatic logic [7:0] clamp_prio(logic [7:0] p, logic [7:0] fl,
                                            logic [7:0] ce);
    logic [7:0] v;
    v = (p < fl) ? fl : p;
    v = (v > ce) ? ce : v;
    return v;
  endfunction

endpackage

// ===== src/prrs_ram.sv =====
module prrs_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== src/prrs_ctrl.sv =====
module prrs_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  prrs_pkg::sts_t       sts_i,
  output prrs_pkg::cmd_t       cmd_o
);
  typedef enum logic [6:0] {
    SIdle = 7'b0000001,
    SDisp = 7'b0000010,
    SWake = 7'b0000100,
    SPost = 7'b0001000,
    SScan = 7'b0010000,
    SFin  = 7'b0100000,
    SOut  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [2:0] act_q, act_d;

  assign in_stall_o  = (state_q != SIdle);
  assign out_valid_o = (state_q == SOut);

  always_comb begin
    state_d = state_q;
    act_d   = act_q;
    cmd_o   = '0;
    unique case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = SDisp;
        end
      end
      SDisp: begin
        act_d = sts_i.next_act;
        priority case (sts_i.next_act)
          prrs_pkg::ActWake: begin
            cmd_o.scan_init = 1'b1;
            cmd_o.scan_kind = prrs_pkg::ScanWake;
            state_d = SWake;
          end
          prrs_pkg::ActNext, prrs_pkg::ActStart: begin
            cmd_o.scan_init = 1'b1;
            cmd_o.scan_kind = prrs_pkg::ScanNext;
            state_d = SScan;
          end
          default: state_d = SOut;
        endcase
      end
      SWake: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_last) state_d = SPost;
      end
      SPost: begin
        cmd_o.tick_post = 1'b1;
        act_d = sts_i.next_act;
        priority case (sts_i.next_act)
          prrs_pkg::ActHigh: begin
            cmd_o.scan_init = 1'b1;
            cmd_o.scan_kind = prrs_pkg::ScanHigh;
            state_d = SScan;
          end
          prrs_pkg::ActQEnd: begin
            cmd_o.scan_init = 1'b1;
            cmd_o.scan_kind = prrs_pkg::ScanNext;
            state_d = SScan;
          end
          default: state_d = SOut;
        endcase
      end
      SScan: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_last) state_d = SFin;
      end
      SFin: begin
        cmd_o.resched   = (act_q == prrs_pkg::ActNext);
        cmd_o.start_fin = (act_q == prrs_pkg::ActStart);
        cmd_o.tick_fin  = (act_q == prrs_pkg::ActHigh) || (act_q == prrs_pkg::ActQEnd);
        state_d = SOut;
      end
      SOut: begin
        cmd_o.emit = 1'b1;
        if (!out_stall_i) state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      act_q   <= prrs_pkg::ActDone;
    end else begin
      state_q <= state_d;
      act_q   <= act_d;
    end
  end
endmodule

// ===== src/prrs_dp.sv =====
module prrs_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  prrs_pkg::cmd_t                cmd_i,
  output prrs_pkg::sts_t                sts_o,
  input  logic [2:0]                    operation_i,
  input  logic [3:0]                    task_index_i,
  input  logic [7:0]                    requested_priority_i,
  input  logic [31:0]                   sleep_ticks_i,
  input  logic [15:0]                   quantum_i,
  input  logic [7:0]                    floor_i,
  input  logic [7:0]                    ceiling_i,
  output logic [1:0]                    status_o,
  output logic [3:0]                    running_task_o,
  output logic                          running_valid_o,
  output logic                          switched_o,
  output logic [3:0]                    created_index_o,
  output logic [7:0]                    running_priority_o,
  output logic [4:0]                    tasks_in_use_o
);
  localparam int N = prrs_pkg::MaxTasks;
  localparam int IW = prrs_pkg::IdxW;
  localparam int CW = prrs_pkg::CntW;

  // small per-task fields kept in flops; wake times in RAM
  logic [1:0]  tstat_q [N];
  logic [7:0]  prio_q  [N];
  logic [15:0] qleft_q [N];
  logic [15:0] slen_q  [N];

  logic [CW-1:0] total_q;
  logic [IW-1:0] cur_q, old_cur_q;
  logic          pres_q, old_pres_q;
  logic [63:0]   now_q;
  logic [2:0]    op_q;
  logic [31:0]   ms_q;
  logic [1:0]    status_q;
  logic [3:0]    created_q;

  // scan
  prrs_pkg::scan_e kind_q;
  logic [CW-1:0] k_q;       // step counter
  logic [IW-1:0] pos_q;     // rotation position
  logic          rd_pend_q; // wake RAM read in flight
  logic [IW-1:0] rd_pos_q;
  logic          best_v_q;
  logic [IW-1:0] best_q;
  logic [7:0]    bestp_q;

  // wake time RAM
  logic          ram_we;
  logic [IW-1:0] ram_wa, ram_ra;
  logic [63:0]   ram_wd, ram_rd;

  prrs_ram #(.Width(64), .Depth(N)) u_wake (
    .clk_i, .we_i(ram_we), .waddr_i(ram_wa), .wdata_i(ram_wd),
    .raddr_i(ram_ra), .rdata_o(ram_rd)
  );

  // next action after dispatch; scan end flag
  always_comb begin
    // wake sweep ends later than the other scans, since the RAM read is registered
    sts_o.scan_last = (kind_q == prrs_pkg::ScanWake) ?
        (k_q >= total_q) : (k_q + CW'(1) >= total_q) || (total_q == '0);
    sts_o.next_act = prrs_pkg::ActDone;
    if (cmd_i.tick_post) begin
      if (pres_q && tstat_q[cur_q] == prrs_pkg::StRun) begin
        if (qleft_q[cur_q] > 16'd1) sts_o.next_act = prrs_pkg::ActHigh;
        else sts_o.next_act = prrs_pkg::ActQEnd;
      end
    end else begin
      unique case (op_q)
        prrs_pkg::OpTick: sts_o.next_act = prrs_pkg::ActWake;
        prrs_pkg::OpYield, prrs_pkg::OpSleep, prrs_pkg::OpExit:
          if (pres_q) sts_o.next_act = prrs_pkg::ActNext;
        prrs_pkg::OpStart:
          if (!pres_q) sts_o.next_act = prrs_pkg::ActStart;
        default: sts_o.next_act = prrs_pkg::ActDone;
      endcase
    end
  end

  assign ram_ra = pos_q;

  always_comb begin
    ram_we = 1'b0;
    ram_wa = cur_q;
    ram_wd = now_q + {32'd0, ms_q};
    if (cmd_i.scan_init && op_q == prrs_pkg::OpSleep && pres_q) begin
      ram_we = 1'b1;
    end
  end

  logic [IW-1:0] start_pos, wrap_pos;
  always_comb begin
    start_pos = '0;
    if (pres_q && ({1'b0, cur_q} + 1'b1) < {1'b0, total_q[IW-1:0]} | (total_q == CW'(N) &&
        cur_q != IW'(N-1)))
      start_pos = cur_q + IW'(1);
    wrap_pos = (({1'b0, pos_q} + 1'b1) >= (IW+1)'(total_q)) ? '0 : pos_q + IW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < N; i++) tstat_q[i] <= prrs_pkg::StReady;
      total_q    <= '0;
      cur_q      <= '0;
      pres_q     <= 1'b0;
      now_q      <= '0;
      k_q        <= '0;
      rd_pend_q  <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        old_cur_q  <= cur_q;
        old_pres_q <= pres_q;
        created_q  <= '0;
        status_q   <= prrs_pkg::StsOk;
        unique case (operation_i)
          prrs_pkg::OpTick: now_q <= now_q + 64'd1;
          prrs_pkg::OpCreate: begin
            if (total_q >= CW'(N)) status_q <= prrs_pkg::StsFull;
            else begin
              created_q <= 4'(total_q);
              prio_q[total_q[IW-1:0]]  <= prrs_pkg::clamp_prio(requested_priority_i,
                                                               floor_i, ceiling_i);
              slen_q[total_q[IW-1:0]]  <= quantum_i;
              qleft_q[total_q[IW-1:0]] <= quantum_i;
              tstat_q[total_q[IW-1:0]] <= prrs_pkg::StReady;
              total_q <= total_q + CW'(1);
            end
          end
          prrs_pkg::OpYield, prrs_pkg::OpSleep, prrs_pkg::OpExit: begin
            if (!pres_q) status_q <= prrs_pkg::StsNoCur;
            else if (operation_i == prrs_pkg::OpSleep)
              tstat_q[cur_q] <= prrs_pkg::StSleep;
            else if (operation_i == prrs_pkg::OpExit)
              tstat_q[cur_q] <= prrs_pkg::StDead;
          end
          prrs_pkg::OpWake: begin
            if ({1'b0, task_index_i} >= 5'(total_q)) status_q <= prrs_pkg::StsBadIdx;
            else if (tstat_q[task_index_i[IW-1:0]] == prrs_pkg::StSleep)
              tstat_q[task_index_i[IW-1:0]] <= prrs_pkg::StReady;
          end
          prrs_pkg::OpSetPri: begin
            if ({1'b0, task_index_i} >= 5'(total_q)) status_q <= prrs_pkg::StsBadIdx;
            else prio_q[task_index_i[IW-1:0]] <= prrs_pkg::clamp_prio(
                requested_priority_i, floor_i, ceiling_i);
          end
          default: ;
        endcase
        op_q  <= operation_i;
        ms_q  <= sleep_ticks_i;
      end

      if (cmd_i.scan_init) begin
        kind_q    <= cmd_i.scan_kind;
        k_q       <= '0;
        best_v_q  <= 1'b0;
        rd_pend_q <= 1'b0;
        unique case (cmd_i.scan_kind)
          prrs_pkg::ScanNext: pos_q <= start_pos;
          default: pos_q <= '0;
        endcase
        bestp_q <= (cmd_i.scan_kind == prrs_pkg::ScanHigh) ? prio_q[cur_q] : 8'd0;
        // reschedule: running task goes back to ready with a full slice
        if (op_q != prrs_pkg::OpTick && op_q != prrs_pkg::OpStart &&
            tstat_q[cur_q] == prrs_pkg::StRun) begin
          tstat_q[cur_q] <= prrs_pkg::StReady;
          qleft_q[cur_q] <= slen_q[cur_q];
        end
      end

      if (cmd_i.scan_step) begin
        if (kind_q == prrs_pkg::ScanWake) begin
          k_q       <= k_q + CW'(1);
          pos_q     <= pos_q + IW'(1);
          rd_pend_q <= ({1'b0, k_q} < (CW+1)'(total_q));
          rd_pos_q  <= pos_q;
          if (rd_pend_q && tstat_q[rd_pos_q] == prrs_pkg::StSleep && ram_rd <= now_q)
            tstat_q[rd_pos_q] <= prrs_pkg::StReady;
        end else begin
          k_q   <= k_q + CW'(1);
          pos_q <= wrap_pos;
          if (total_q != '0 && tstat_q[pos_q] == prrs_pkg::StReady) begin
            if (kind_q == prrs_pkg::ScanHigh) begin
              if (prio_q[pos_q] < bestp_q) begin
                best_v_q <= 1'b1; best_q <= pos_q; bestp_q <= prio_q[pos_q];
              end
            end else if (!best_v_q || prio_q[pos_q] < bestp_q) begin
              best_v_q <= 1'b1; best_q <= pos_q; bestp_q <= prio_q[pos_q];
            end
          end
        end
      end

      if (cmd_i.tick_post && pres_q && tstat_q[cur_q] == prrs_pkg::StRun) begin
        if (qleft_q[cur_q] > 16'd1) qleft_q[cur_q] <= qleft_q[cur_q] - 16'd1;
        else begin
          qleft_q[cur_q] <= slen_q[cur_q];
          tstat_q[cur_q] <= prrs_pkg::StReady;
        end
      end

      if (cmd_i.resched || (cmd_i.tick_fin && op_q == prrs_pkg::OpTick &&
          !(best_v_q && kind_q == prrs_pkg::ScanHigh))) begin
        if (cmd_i.resched || kind_q == prrs_pkg::ScanNext) begin
          if (!best_v_q || best_q == cur_q) tstat_q[cur_q] <= prrs_pkg::StRun;
          else begin
            tstat_q[best_q] <= prrs_pkg::StRun;
            cur_q <= best_q;
          end
        end
      end
      if (cmd_i.tick_fin && kind_q == prrs_pkg::ScanHigh && best_v_q) begin
        tstat_q[cur_q]  <= prrs_pkg::StReady;
        tstat_q[best_q] <= prrs_pkg::StRun;
        cur_q <= best_q;
      end
      if (cmd_i.start_fin) begin
        if (!best_v_q) status_q <= prrs_pkg::StsNoCur;
        else begin
          cur_q  <= best_q;
          pres_q <= 1'b1;
          tstat_q[best_q] <= prrs_pkg::StRun;
        end
      end
    end
  end

  assign status_o           = status_q;
  assign running_task_o     = pres_q ? 4'(cur_q) : 4'd0;
  assign running_valid_o    = pres_q;
  assign switched_o         = (pres_q != old_pres_q) || (pres_q && cur_q != old_cur_q);
  assign created_index_o    = created_q;
  assign running_priority_o = pres_q ? prio_q[cur_q] : 8'd0;
  assign tasks_in_use_o     = 5'(total_q);
endmodule

// ===== src/priority_round_robin_task_scheduler.sv =====
// Create, wake, set priority and start while running go from dispatch straight
//   to the result; yield, sleep, exit and start add a pick scan over the tasks
//   created; a tick adds a wake sweep, and with a running task a pick scan.
// One event at a time: the input stalls until the last result is taken; the
//   per-task scan over the task table sets the pace.
// Reset (rst_ni low, asynchronous): all tasks ready and unused, no current
//   task, clock at zero, registers at their defaults.
module priority_round_robin_task_scheduler (
  input  logic        clk_i,
  input  logic        rst_ni,
  // event transfer in
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  operation_i,
  input  logic [3:0]  task_index_i,
  input  logic [7:0]  requested_priority_i,
  input  logic [31:0] sleep_ticks_i,
  // result transfer out
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [3:0]  running_task_o,
  output logic        running_valid_o,
  output logic        switched_o,
  output logic [3:0]  created_index_o,
  output logic [7:0]  running_priority_o,
  output logic [4:0]  tasks_in_use_o,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [15:0] quantum_q;
  logic [7:0]  floor_q, ceiling_q;
  logic [1:0]  reg_sel;

  prrs_pkg::cmd_t cmd;
  prrs_pkg::sts_t sts;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];

  // Hold the registers; write on the access phase of a transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quantum_q <= 16'd10;
      floor_q   <= 8'd0;
      ceiling_q <= 8'd255;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      unique case (reg_sel)
        prrs_pkg::RegQuantum: quantum_q <= pwdata[15:0];
        prrs_pkg::RegFloor:   floor_q   <= pwdata[7:0];
        prrs_pkg::RegCeiling: ceiling_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      prrs_pkg::RegQuantum: prdata = {16'd0, quantum_q};
      prrs_pkg::RegFloor:   prdata = {24'd0, floor_q};
      prrs_pkg::RegCeiling: prdata = {24'd0, ceiling_q};
      default:              prdata = 32'd0;
    endcase
  end

  // Sequence each event: dispatch, optional wake sweep, optional pick scan, result.
  prrs_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  prrs_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .operation_i, .task_index_i, .requested_priority_i, .sleep_ticks_i,
    .quantum_i(quantum_q), .floor_i(floor_q), .ceiling_i(ceiling_q),
    .status_o, .running_task_o, .running_valid_o, .switched_o,
    .created_index_o, .running_priority_o, .tasks_in_use_o
  );
endmodule

// ===== src/prrs_checker.sv =====
module prrs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       running_valid_o,
  input logic [3:0] running_task_o,
  input logic [7:0] running_priority_o,
  input logic [4:0] tasks_in_use_o
);
  ap_stall_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input taken while result pending");
  ap_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(running_task_o))
    else $error("stalled result changed");
  ap_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !running_valid_o |-> running_task_o == 4'd0 &&
    running_priority_o == 8'd0) else $error("idle result not zero");
  ap_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tasks_in_use_o <= 5'd16) else $error("task count overflow");
endmodule

bind priority_round_robin_task_scheduler prrs_checker u_chk (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
  .running_valid_o, .running_task_o, .running_priority_o, .tasks_in_use_o
);
